/* hdl/wsh_pkg.sv */
// ----------------------------------------------------------------------------
// Width-selectable stream hash package
// Shared types, mixing constants and lookup functions for the hash blocks.
// ----------------------------------------------------------------------------
package wsh_pkg;

	typedef enum logic [1:0] {
		WC_8  = 2'd0,
		WC_16 = 2'd1,
		WC_32 = 2'd2,
		WC_64 = 2'd3
	} width_code_t;

	localparam int WSH_FIFO_DEPTH = 4;

	localparam logic [31:0] MIX_MUL_8   = 32'd81;
	localparam logic [31:0] MIX_MUL_16  = 32'd11601;
	localparam logic [31:0] MIX_MUL_32  = 32'd3432918353;
	localparam logic [63:0] MIX_MUL_64  = 64'd14744272059406101841;
	localparam logic [63:0] ADD_8       = 64'd237;
	localparam logic [63:0] ADD_16      = 64'd12525;
	localparam logic [63:0] ADD_32      = 64'd2041000173;
	localparam logic [63:0] ADD_64      = 64'd8766028991911375085;

	typedef struct packed {
		logic [63:0] mixed;
		width_code_t code;
		logic        last;
	} mix_t;

	function automatic logic [31:0] mix_mul_lo(width_code_t code);
		logic [31:0] c;
		case (code)
			WC_8:    c = MIX_MUL_8;
			WC_16:   c = MIX_MUL_16;
			WC_32:   c = MIX_MUL_32;
			WC_64:   c = MIX_MUL_64[31:0];
			default: c = MIX_MUL_8;
		endcase
		return c;
	endfunction

	function automatic logic [63:0] add_const(width_code_t code);
		logic [63:0] c;
		case (code)
			WC_8:    c = ADD_8;
			WC_16:   c = ADD_16;
			WC_32:   c = ADD_32;
			WC_64:   c = ADD_64;
			default: c = ADD_8;
		endcase
		return c;
	endfunction

endpackage

/* hdl/wsh_ifs.sv */
// ----------------------------------------------------------------------------
// Width-selectable stream hash channels
// Valid/ready channels for elements, configuration writes and hash results.
// ----------------------------------------------------------------------------
interface wsh_elem_if;
	logic        valid;
	logic        ready;
	logic [63:0] element;
	logic        last_element;

	modport source (output valid, output element, output last_element, input ready);
	modport sink (input valid, input element, input last_element, output ready);
endinterface

interface wsh_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] element_width_code;

	modport source (output valid, output element_width_code, input ready);
	modport sink (input valid, input element_width_code, output ready);
endinterface

interface wsh_hash_if;
	logic        valid;
	logic        ready;
	logic [63:0] hash_value;

	modport source (output valid, output hash_value, input ready);
	modport sink (input valid, input hash_value, output ready);
endinterface

/* hdl/wsh_mixer.sv */
// ----------------------------------------------------------------------------
// Element mixer
// Holds the width register, masks each request and mixes it in two stages.
// ----------------------------------------------------------------------------
module wsh_mixer (
	input  logic          clk,
	input  logic          arst_n,
	wsh_elem_if.sink      elem,
	wsh_cfg_if.sink       cfg,
	output logic          out_valid,
	input  logic          out_ready,
	output wsh_pkg::mix_t out_data
);
	import wsh_pkg::*;

	width_code_t cfg_q;

	logic        v_s1;
	logic [63:0] p0_s1;
	logic [31:0] p1_s1;
	logic [31:0] p2_s1;
	width_code_t code_s1;
	logic        last_s1;

	logic        v_s2;
	mix_t        data_s2;

	logic        adv_s1;
	logic        adv_s2;
	logic        take;
	logic [31:0] e_lo;
	logic [31:0] e_hi;
	logic [31:0] c_lo;
	logic [31:0] c_hi;
	logic [63:0] prod;
	logic [63:0] rot;

	assign cfg.ready = 1'b1;

	assign adv_s2     = !v_s2 || out_ready;
	assign adv_s1     = !v_s1 || adv_s2;
	assign elem.ready = adv_s1;
	assign take       = elem.valid && adv_s1;

	always_comb begin
		e_hi = 32'd0;
		c_hi = 32'd0;
		case (cfg_q)
			WC_8:    e_lo = {24'd0, elem.element[7:0]};
			WC_16:   e_lo = {16'd0, elem.element[15:0]};
			WC_32:   e_lo = elem.element[31:0];
			WC_64: begin
				e_lo = elem.element[31:0];
				e_hi = elem.element[63:32];
				c_hi = MIX_MUL_64[63:32];
			end
			default: e_lo = {24'd0, elem.element[7:0]};
		endcase
		c_lo = mix_mul_lo(cfg_q);
	end

	always_comb begin
		prod = p0_s1 + {p1_s1 + p2_s1, 32'd0};
		case (code_s1)
			WC_8:    rot = {56'd0, prod[3:0], prod[7:4]};
			WC_16:   rot = {48'd0, prod[7:0], prod[15:8]};
			WC_32:   rot = {32'd0, prod[15:0], prod[31:16]};
			WC_64:   rot = {prod[31:0], prod[63:32]};
			default: rot = {56'd0, prod[3:0], prod[7:4]};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= WC_8;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				cfg_q <= width_code_t'(cfg.element_width_code);
			end
			if (adv_s1) begin
				v_s1 <= take;
			end
			if (adv_s2) begin
				v_s2 <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			p0_s1   <= {32'd0, e_lo} * {32'd0, c_lo};
			p1_s1   <= e_lo * c_hi;
			p2_s1   <= e_hi * c_lo;
			code_s1 <= cfg_q;
			last_s1 <= elem.last_element;
		end
		if (adv_s2 && v_s1) begin
			data_s2.mixed <= rot;
			data_s2.code  <= code_s1;
			data_s2.last  <= last_s1;
		end
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;

endmodule

/* hdl/wsh_fifo.sv */
// ----------------------------------------------------------------------------
// Mixed element queue
// Small first-in first-out buffer between the mixer and the accumulator.
// ----------------------------------------------------------------------------
module wsh_fifo #(
	parameter int DEPTH = wsh_pkg::WSH_FIFO_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       push,
	output logic                       push_ready,
	input  wsh_pkg::mix_t              push_data,
	output logic                       head_valid,
	input  logic                       pop,
	output wsh_pkg::mix_t              head_data,
	output logic [$clog2(DEPTH+1)-1:0] count
);
	import wsh_pkg::*;

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	mix_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = count_q != CW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_data  = mem_q[rd_ptr_q];
	assign count      = count_q;
	assign do_push    = push && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hdl/wsh_accum.sv */
// ----------------------------------------------------------------------------
// Hash accumulator
// Folds mixed elements into the running hash and registers finished hashes.
// ----------------------------------------------------------------------------
module wsh_accum (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	output logic          pop,
	input  wsh_pkg::mix_t head_data,
	wsh_hash_if.source    hash,
	output logic          hash_zero
);
	import wsh_pkg::*;

	logic [63:0] run_q;
	logic        out_valid_q;
	logic [63:0] out_hash_q;
	logic [63:0] h_x;
	logic [63:0] h_next;
	logic        out_free;

	assign out_free = !out_valid_q || hash.ready;
	assign pop      = head_valid && (!head_data.last || out_free);
	assign h_x      = run_q ^ head_data.mixed;
	assign h_next   = (h_x << 3) + (h_x << 1) + h_x + add_const(head_data.code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop && head_data.last) begin
				out_valid_q <= 1'b1;
			end else if (hash.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				if (head_data.last) begin
					run_q <= '0;
				end else begin
					run_q <= h_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_data.last) begin
			out_hash_q <= h_next;
		end
	end

	assign hash.valid      = out_valid_q;
	assign hash.hash_value = out_hash_q;
	assign hash_zero       = run_q == '0;

endmodule

/* hdl/width_selectable_stream_hash_top.sv */
// ----------------------------------------------------------------------------
// Width-selectable stream hash
// Hashes a stream of 8, 16, 32 or 64-bit elements into a 64-bit message hash.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// elem     in         element[63:0], last_element
// cfg      in         element_width_code[1:0]
// hash     out        hash_value[63:0], one per message
//
// One element request is taken per cycle when nothing stalls.
// The mixer registers each request as partial products, then as a summed and rotated
// result; the queue registers each mixed element, and the accumulator folds one queued
// element per cycle unless a last element waits on a stalled hash output.
// Reset clears the width register to byte mode and the running hash to zero.
// A stalled hash output blocks only the next last element; the queue and
// the mixer keep accepting until the queue is full.
// ----------------------------------------------------------------------------
module width_selectable_stream_hash_top #(
	parameter int FIFO_DEPTH = wsh_pkg::WSH_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	wsh_elem_if.sink   elem,
	wsh_cfg_if.sink    cfg,
	wsh_hash_if.source hash
);
	import wsh_pkg::*;

	localparam int CW = $clog2(FIFO_DEPTH + 1);

	logic          mix_valid;
	logic          mix_ready;
	mix_t          mix_data;
	logic          head_valid;
	logic          head_pop;
	mix_t          head_data;
	logic [CW-1:0] fifo_count;
	logic          hash_zero;

	wsh_mixer u_mixer (
		.clk       (clk),
		.arst_n    (arst_n),
		.elem      (elem),
		.cfg       (cfg),
		.out_valid (mix_valid),
		.out_ready (mix_ready),
		.out_data  (mix_data)
	);

	wsh_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (mix_valid),
		.push_ready (mix_ready),
		.push_data  (mix_data),
		.head_valid (head_valid),
		.pop        (head_pop),
		.head_data  (head_data),
		.count      (fifo_count)
	);

	wsh_accum u_accum (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.pop        (head_pop),
		.head_data  (head_data),
		.hash       (hash),
		.hash_zero  (hash_zero)
	);

	// A completed message always restarts from a cleared running hash.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(head_pop && head_data.last) |=> hash_zero)
		else $error("running hash not cleared after last element");

	// A waiting hash result must never be overwritten by a new message end.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(hash.valid && !hash.ready) |-> !(head_pop && head_data.last))
		else $error("pending hash overwritten");

	// The queue occupancy tracks pushes and pops exactly.
	a_count_push: assert property (@(posedge clk) disable iff (!arst_n)
		(mix_valid && mix_ready && !head_pop) |=> fifo_count == $past(fifo_count) + 1'b1)
		else $error("queue count lost a push");

	a_count_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(head_pop && !(mix_valid && mix_ready)) |=> fifo_count == $past(fifo_count) - 1'b1)
		else $error("queue count lost a pop");

endmodule
